/* src/clm_pkg.sv */
// Shared constants, operation and status codes, and the free-slot search for
// the circular list manager.
// Depends on nothing; imported by circular_list_manager.
package clm_pkg;

    localparam int CAPACITY = 32;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OP_W     = 3;
    localparam int POS_W    = 8;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 3;
    localparam int LEN_W    = 7;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT_AT    = 3'd0,
        OP_INSERT_FRONT = 3'd1,
        OP_APPEND       = 3'd2,
        OP_DELETE_AT    = 3'd3,
        OP_DELETE_FRONT = 3'd4,
        OP_DELETE_END   = 3'd5,
        OP_TRAVERSE     = 3'd6,
        OP_NOP          = 3'd7
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_POS_ONE = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_RANGE   = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    // Lowest-numbered free slot; zero when none is free.
    function automatic logic [SLOT_W-1:0] lowest_free(input logic [CAPACITY-1:0] free_map);
        logic [SLOT_W-1:0] slot;
        slot = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (free_map[i]) begin
                slot = SLOT_W'(i);
            end
        end
        return slot;
    endfunction

endpackage

/* src/circular_list_manager.sv */
// Circular list manager: an ordered list of signed values kept as a singly
// linked ring in two slot memories (values and successor links).
// Depends on clm_pkg.
//
// Usage:
// A request enters on i_in_valid / o_in_stall with i_operation, i_position
// and i_item_value. Results leave on o_out_valid / i_out_stall. Every
// operation yields one status result, except a traverse of a non-empty list,
// which yields one result per element from front to back; o_last_result
// marks the final result of each request.
// Timing: one request is worked on at a time. Positional insert and delete,
// and delete at the end, walk the ring one link memory read per cycle. A
// traverse streams one element per cycle while the receiver does not stall.
// Results sit in an output register; while the receiver stalls, that
// register holds and the next request's work proceeds up to the point where
// it has a result to hand over, then waits.
// Reset (synchronous, active low) empties the list: the free map is set to
// all ones, the count and tail to zero. The memories themselves are not
// cleared; only slots that were written are ever used.
module circular_list_manager (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [clm_pkg::OP_W-1:0]            i_operation,
    input  logic [clm_pkg::POS_W-1:0]           i_position,
    input  logic signed [clm_pkg::DATA_W-1:0]   i_item_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [clm_pkg::STATUS_W-1:0]        o_status,
    output logic signed [clm_pkg::DATA_W-1:0]   o_element,
    output logic                                o_is_element,
    output logic                                o_last_result,
    output logic [clm_pkg::LEN_W-1:0]           o_list_length
);
    import clm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_INS1,
        S_INS2,
        S_FIRST,
        S_DEL,
        S_TRAV,
        S_RESP
    } t_state;

    // Control and list bookkeeping.
    t_state                    r_state;
    t_op                       r_op;
    t_status                   r_status;
    logic signed [DATA_W-1:0]  r_val;
    logic [POS_W-1:0]          r_target;
    logic [POS_W-1:0]          r_steps;
    logic                      r_stop_tail;
    logic [SLOT_W-1:0]         r_cur;
    logic [SLOT_W-1:0]         r_next;
    logic [SLOT_W-1:0]         r_slot;
    logic [SLOT_W-1:0]         r_tail;
    logic [CNT_W-1:0]          r_count;
    logic [CAPACITY-1:0]       r_free;

    // Decode of the request on the input ports, taken when it is accepted.
    t_state                    n_state;
    t_status                   n_status;
    logic [POS_W-1:0]          n_target;
    logic                      n_stop_tail;

    // Output register.
    logic                      r_out_valid;
    t_status                   r_o_status;
    logic signed [DATA_W-1:0]  r_o_element;
    logic                      r_o_is_element;
    logic                      r_o_last;
    logic [LEN_W-1:0]          r_o_length;

    // Slot memories with registered read data.
    logic [SLOT_W-1:0]         lk_mem [CAPACITY];
    logic signed [DATA_W-1:0]  vl_mem [CAPACITY];
    logic [SLOT_W-1:0]         q_link;
    logic signed [DATA_W-1:0]  q_val;

    logic [SLOT_W-1:0]         rd_addr;
    logic                      lk_we;
    logic [SLOT_W-1:0]         lk_waddr;
    logic [SLOT_W-1:0]         lk_wdata;
    logic                      vl_we;

    logic                      out_free;
    logic                      walk_step;
    logic                      last_elem;
    logic                      list_empty;
    logic                      list_full;
    logic [SLOT_W-1:0]         new_slot;
    t_op                       op_in;

    assign op_in      = t_op'(i_operation);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign list_empty = (r_count == '0);
    assign list_full  = (r_count >= CNT_W'(CAPACITY));
    assign new_slot   = lowest_free(r_free);
    assign last_elem  = ((r_steps + POS_W'(1)) == POS_W'(r_count));

    // During the walk q_link always holds the successor of r_cur. The first
    // step, if the target is non-zero, is always taken; an insert walk also stops at the tail.
    assign walk_step = (r_steps < r_target)
                    && !(r_stop_tail && (r_steps != '0) && (r_cur == r_tail));

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_o_status;
    assign o_element     = r_o_element;
    assign o_is_element  = r_o_is_element;
    assign o_last_result = r_o_last;
    assign o_list_length = r_o_length;

    // Rejections answer at once; accepted work starts with a walk of the ring
    // from the tail, or with the first entry of an empty list.
    always_comb begin
        n_status    = ST_OK;
        n_state     = S_RESP;
        n_target    = '0;
        n_stop_tail = 1'b0;
        unique case (op_in) inside
            OP_INSERT_AT: begin
                if (i_position == POS_W'(1)) begin
                    n_status = ST_POS_ONE;
                end else if (list_empty) begin
                    n_status = ST_EMPTY;
                end else if (list_full) begin
                    n_status = ST_FULL;
                end else begin
                    // Positions 0 and 2 both land after the front.
                    n_target    = (i_position >= POS_W'(2))
                                ? i_position - POS_W'(1) : POS_W'(1);
                    n_stop_tail = 1'b1;
                    n_state     = S_WALK;
                end
            end
            OP_INSERT_FRONT, OP_APPEND: begin
                if (list_full) begin
                    n_status = ST_FULL;
                end else if (list_empty) begin
                    n_state = S_FIRST;
                end else begin
                    n_state = S_WALK;
                end
            end
            OP_DELETE_AT: begin
                if (i_position == POS_W'(1)) begin
                    n_status = ST_POS_ONE;
                end else if (list_empty) begin
                    n_status = ST_EMPTY;
                end else if ((i_position < POS_W'(2))
                          || (i_position > POS_W'(r_count))) begin
                    n_status = ST_RANGE;
                end else begin
                    n_target = i_position - POS_W'(1);
                    n_state  = S_WALK;
                end
            end
            OP_DELETE_FRONT: begin
                if (list_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_state = S_WALK;
                end
            end
            OP_DELETE_END: begin
                if (list_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_target = POS_W'(r_count) - POS_W'(1);
                    n_state  = S_WALK;
                end
            end
            OP_TRAVERSE: begin
                if (list_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_target = POS_W'(1);
                    n_state  = S_WALK;
                end
            end
            OP_NOP: begin
                n_status = ST_OK;
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // Memory addressing and write strobes for each state.
    always_comb begin
        rd_addr  = r_tail;
        lk_we    = 1'b0;
        lk_waddr = r_cur;
        lk_wdata = r_next;
        vl_we    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                rd_addr = r_tail;
            end
            S_WALK: begin
                // A traverse re-reads the front slot so that its value arrives.
                // Every other walk reads ahead so a delete has the link it skips.
                rd_addr = (!walk_step && (r_op == OP_TRAVERSE)) ? r_cur : q_link;
            end
            S_INS1: begin
                lk_we    = 1'b1;
                lk_waddr = new_slot;
                lk_wdata = r_next;
                vl_we    = 1'b1;
            end
            S_INS2: begin
                lk_we    = 1'b1;
                lk_waddr = r_cur;
                lk_wdata = r_slot;
            end
            S_FIRST: begin
                lk_we    = 1'b1;
                lk_waddr = new_slot;
                lk_wdata = new_slot;
                vl_we    = 1'b1;
            end
            S_DEL: begin
                lk_we    = (r_count > CNT_W'(1));
                lk_waddr = r_cur;
                lk_wdata = q_link;
            end
            S_TRAV: begin
                rd_addr = out_free ? q_link : r_cur;
            end
            S_RESP: begin
                rd_addr = r_tail;
            end
            default: begin
                rd_addr = r_tail;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (lk_we) begin
            lk_mem[lk_waddr] <= lk_wdata;
        end
        q_link <= lk_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (vl_we) begin
            vl_mem[new_slot] <= r_val;
        end
        q_val <= vl_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tail      <= '0;
            r_count     <= '0;
            r_free      <= '1;
            r_out_valid <= 1'b0;
        end else begin
            // The result states reload the output register themselves.
            if (r_out_valid && !i_out_stall
                    && (r_state != S_TRAV) && (r_state != S_RESP)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op        <= op_in;
                        r_val       <= i_item_value;
                        r_cur       <= r_tail;
                        r_steps     <= '0;
                        r_target    <= n_target;
                        r_stop_tail <= n_stop_tail;
                        r_status    <= n_status;
                        r_state     <= n_state;
                    end
                end
                S_WALK: begin
                    if (walk_step) begin
                        r_cur   <= q_link;
                        r_steps <= r_steps + POS_W'(1);
                    end else begin
                        r_next  <= q_link;
                        r_steps <= '0;
                        unique case (r_op) inside
                            OP_INSERT_AT, OP_INSERT_FRONT, OP_APPEND: r_state <= S_INS1;
                            OP_DELETE_AT, OP_DELETE_FRONT, OP_DELETE_END: r_state <= S_DEL;
                            OP_TRAVERSE: r_state <= S_TRAV;
                            default: r_state <= S_RESP;
                        endcase
                    end
                end
                S_INS1: begin
                    r_slot           <= new_slot;
                    r_free[new_slot] <= 1'b0;
                    r_count          <= r_count + CNT_W'(1);
                    r_state          <= S_INS2;
                end
                S_INS2: begin
                    if (((r_op == OP_INSERT_AT) && (r_cur == r_tail))
                            || (r_op == OP_APPEND)) begin
                        r_tail <= r_slot;
                    end
                    r_state <= S_RESP;
                end
                S_FIRST: begin
                    r_free[new_slot] <= 1'b0;
                    r_tail           <= new_slot;
                    r_count          <= CNT_W'(1);
                    r_state          <= S_RESP;
                end
                S_DEL: begin
                    r_free[r_next] <= 1'b1;
                    if (r_count <= CNT_W'(1)) begin
                        r_count <= '0;
                        r_tail  <= '0;
                    end else begin
                        if (r_next == r_tail) begin
                            r_tail <= r_cur;
                        end
                        r_count <= r_count - CNT_W'(1);
                    end
                    r_state <= S_RESP;
                end
                S_TRAV: begin
                    if (out_free) begin
                        r_out_valid    <= 1'b1;
                        r_o_status     <= ST_OK;
                        r_o_element    <= q_val;
                        r_o_is_element <= 1'b1;
                        r_o_last       <= last_elem;
                        r_o_length     <= LEN_W'(r_count);
                        r_steps        <= r_steps + POS_W'(1);
                        r_cur          <= q_link;
                        if (last_elem) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_RESP: begin
                    if (out_free) begin
                        r_out_valid    <= 1'b1;
                        r_o_status     <= r_status;
                        r_o_element    <= '0;
                        r_o_is_element <= 1'b0;
                        r_o_last       <= 1'b1;
                        r_o_length     <= LEN_W'(r_count);
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* dv/tb_circular_list_manager.sv */
// Self-checking testbench for circular_list_manager: random and directed list requests,
// with results checked against a queue-based model of the list contents.
// Depends on clm_pkg and circular_list_manager; stands alone otherwise.
module tb_circular_list_manager;
    timeunit 1ns;
    timeprecision 1ps;

    import clm_pkg::*;

    // Run length and safety limits. The slowest correct run is bounded by
    // roughly 420 requests, each at most CAPACITY results, each result held
    // up by a receiver that stalls on about 64 in 100 chances. The limit
    // below is several times that figure.
    localparam int RANDOM_REQUESTS = 380;
    localparam int PHASE_SPAN      = 40;
    localparam int DRAIN_CYCLES    = 48;
    localparam int CYCLE_LIMIT     = 400000;

    localparam logic signed [DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

    // One request waiting to be driven. The phase selects how often each
    // side idles while this request is in flight. When drain_first is set,
    // the sender holds the request back until every result has come.
    typedef struct {
        logic [OP_W-1:0]          op;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] value;
        bit                       drain_first;
        int unsigned              phase;
    } t_list_request;

    // One result that the list is expected to produce.
    typedef struct {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] element;
        logic                     is_element;
        logic                     last_result;
        logic [LEN_W-1:0]         list_length;
    } t_list_result;

    logic                       i_clk;
    logic                       i_rst_n      = 1'b0;
    logic                       i_in_valid   = 1'b0;
    logic                       o_in_stall;
    logic [OP_W-1:0]            i_operation  = '0;
    logic [POS_W-1:0]           i_position   = '0;
    logic signed [DATA_W-1:0]   i_item_value = '0;
    logic                       o_out_valid;
    logic                       i_out_stall  = 1'b0;
    logic [STATUS_W-1:0]        o_status;
    logic signed [DATA_W-1:0]   o_element;
    logic                       o_is_element;
    logic                       o_last_result;
    logic [LEN_W-1:0]           o_list_length;

    // Requests still to be driven, the list contents as the model sees them,
    // and the results owed by the block, oldest first.
    t_list_request            pending_requests[$];
    logic signed [DATA_W-1:0] list_contents[$];
    t_list_result             owed_results[$];

    t_list_request next_request;
    int unsigned   traffic_phase     = 0;
    int unsigned   requests_accepted = 0;
    int unsigned   results_checked   = 0;
    int unsigned   error_count       = 0;
    int unsigned   longest_list      = 0;
    int unsigned   full_rejections   = 0;
    int unsigned   cycle_count       = 0;

    circular_list_manager u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_position    (i_position),
        .i_item_value  (i_item_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_element     (o_element),
        .o_is_element  (o_is_element),
        .o_last_result (o_last_result),
        .o_list_length (o_list_length)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Owe one status result: no element, always the last result of its request.
    task automatic owe_status(input t_status st);
        owed_results.push_back('{status: st, element: '0, is_element: 1'b0,
                                 last_result: 1'b1,
                                 list_length: LEN_W'(list_contents.size())});
    endtask

    // Applies one accepted request to the list and queues the results it owes.
    // The list is held as a plain queue of values, front first; the ring of
    // slots inside the block is invisible from outside.
    task automatic apply_list_request(input logic [OP_W-1:0] op,
                                      input logic [POS_W-1:0] pos,
                                      input logic signed [DATA_W-1:0] value);
        t_status st;
        int      place;
        int      count;
        st    = ST_OK;
        count = list_contents.size();
        case (t_op'(op))
            OP_INSERT_AT: begin
                if (pos == POS_W'(1)) begin
                    st = ST_POS_ONE;
                end else if (count == 0) begin
                    st = ST_EMPTY;
                end else if (count >= CAPACITY) begin
                    st = ST_FULL;
                end else begin
                    // Positions below two land at position two; positions past
                    // the end append.
                    place = (pos < 2) ? 2 : int'(pos);
                    if (place > count + 1) begin
                        place = count + 1;
                    end
                    list_contents.insert(place - 1, value);
                end
            end
            OP_INSERT_FRONT, OP_APPEND: begin
                if (count >= CAPACITY) begin
                    st = ST_FULL;
                end else if (t_op'(op) == OP_INSERT_FRONT) begin
                    list_contents.push_front(value);
                end else begin
                    list_contents.push_back(value);
                end
            end
            OP_DELETE_AT: begin
                if (pos == POS_W'(1)) begin
                    st = ST_POS_ONE;
                end else if (count == 0) begin
                    st = ST_EMPTY;
                end else if (pos < 2 || int'(pos) > count) begin
                    st = ST_RANGE;
                end else begin
                    list_contents.delete(int'(pos) - 1);
                end
            end
            OP_DELETE_FRONT: begin
                if (count == 0) begin
                    st = ST_EMPTY;
                end else begin
                    void'(list_contents.pop_front());
                end
            end
            OP_DELETE_END: begin
                if (count == 0) begin
                    st = ST_EMPTY;
                end else begin
                    void'(list_contents.pop_back());
                end
            end
            OP_TRAVERSE: begin
                if (count == 0) begin
                    st = ST_EMPTY;
                end else begin
                    // A traverse of a non-empty list owes one result per value,
                    // front to back, and no status result.
                    for (int k = 0; k < count; k++) begin
                        owed_results.push_back('{status: ST_OK,
                                                 element: list_contents[k],
                                                 is_element: 1'b1,
                                                 last_result: (k == count - 1),
                                                 list_length: LEN_W'(count)});
                    end
                    return;
                end
            end
            default: begin
                // The spare operation code leaves the list alone.
            end
        endcase
        if (st == ST_FULL) begin
            full_rejections++;
        end
        if (list_contents.size() > longest_list) begin
            longest_list = list_contents.size();
        end
        owe_status(st);
    endtask

    // Compares the result on the output ports with the oldest owed result.
    task automatic check_list_result();
        t_list_result owed;
        if (owed_results.size() == 0) begin
            $error("Result with nothing owed: status %0d element %0d", o_status, o_element);
            error_count++;
            return;
        end
        owed = owed_results.pop_front();
        results_checked++;
        if (o_status !== owed.status) begin
            $error("status: expected %0d, got %0d", owed.status, o_status);
            error_count++;
        end
        if (o_element !== owed.element) begin
            $error("element: expected %0d, got %0d", owed.element, o_element);
            error_count++;
        end
        if (o_is_element !== owed.is_element) begin
            $error("is_element: expected %0d, got %0d", owed.is_element, o_is_element);
            error_count++;
        end
        if (o_last_result !== owed.last_result) begin
            $error("last_result: expected %0d, got %0d", owed.last_result, o_last_result);
            error_count++;
        end
        if (o_list_length !== owed.list_length) begin
            $error("list_length: expected %0d, got %0d", owed.list_length, o_list_length);
            error_count++;
        end
    endtask

    task automatic add_request(input t_op op, input int pos,
                               input logic signed [DATA_W-1:0] value,
                               input bit drain_first, input int unsigned phase);
        pending_requests.push_back('{op: op, pos: POS_W'(pos), value: value,
                                     drain_first: drain_first, phase: phase});
    endtask

    // Request driver. A request is accepted at an edge where valid is high
    // and stall is low; only then, or while valid is low, may a new request
    // be put on the ports, so a stalled request never changes.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                apply_list_request(i_operation, i_position, i_item_value);
                requests_accepted++;
            end
            if (!i_in_valid || !o_in_stall) begin
                // Idle by phase: none, often, never, or now and then. A request
                // marked drain_first waits until every owed result has come.
                if (pending_requests.size() != 0
                        && !(pending_requests[0].drain_first && owed_results.size() != 0)
                        && $urandom_range(0, 99) >= ((pending_requests[0].phase == 1) ? 64 :
                                                     (pending_requests[0].phase == 3) ? 30 : 0))
                begin
                    next_request = pending_requests.pop_front();
                    i_in_valid    <= 1'b1;
                    i_operation   <= next_request.op;
                    i_position    <= next_request.pos;
                    i_item_value  <= next_request.value;
                    traffic_phase <= next_request.phase;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor. Checks each accepted result, then picks the stall for
    // the next cycle from the phase of the request most recently driven.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                check_list_result();
            end
            i_out_stall <= ($urandom_range(0, 99) < ((traffic_phase == 2) ? 64 :
                                                      (traffic_phase == 3) ? 30 : 0));
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still owed",
                     cycle_count, owed_results.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int unsigned seg_index;
        int unsigned seg_kind;
        int unsigned seg_len;
        int unsigned random_count;
        int unsigned roll;
        int unsigned insert_limit;
        int unsigned delete_limit;
        t_op         op;
        int          pos;
        logic signed [DATA_W-1:0] value;

        // Directed part. Everything on an empty list is rejected first, then a
        // short list is built with the value extremes, checked by traversal,
        // and taken apart through every delete path down to empty again.
        add_request(OP_TRAVERSE,     0,   32'sd0,       1'b0, 0);
        add_request(OP_DELETE_FRONT, 0,   32'sd0,       1'b0, 0);
        add_request(OP_DELETE_END,   0,   32'sd0,       1'b0, 0);
        add_request(OP_DELETE_AT,    3,   32'sd0,       1'b0, 0);
        add_request(OP_INSERT_AT,    1,   32'sd5,       1'b0, 0);
        add_request(OP_INSERT_AT,    5,   32'sd6,       1'b0, 0);
        add_request(OP_NOP,          255, -32'sd1,      1'b0, 0);
        add_request(OP_APPEND,       0,   VALUE_MAX,    1'b0, 0);
        add_request(OP_INSERT_FRONT, 0,   VALUE_MIN,    1'b0, 0);
        add_request(OP_INSERT_AT,    0,   -32'sd1,      1'b0, 0);
        add_request(OP_INSERT_AT,    2,   32'sd0,       1'b0, 0);
        add_request(OP_INSERT_AT,    255, 32'h5555_5555, 1'b0, 0);
        add_request(OP_INSERT_AT,    3,   32'hAAAA_AAAA, 1'b0, 0);
        add_request(OP_TRAVERSE,     0,   32'sd0,       1'b0, 0);
        add_request(OP_DELETE_AT,    1,   32'sd0,       1'b0, 0);
        add_request(OP_DELETE_AT,    0,   32'sd0,       1'b0, 0);
        add_request(OP_DELETE_AT,    200, 32'sd0,       1'b0, 0);
        add_request(OP_DELETE_AT,    6,   32'sd0,       1'b0, 0);
        add_request(OP_DELETE_AT,    2,   32'sd0,       1'b0, 0);
        add_request(OP_DELETE_FRONT, 0,   32'sd0,       1'b0, 0);
        add_request(OP_DELETE_END,   0,   32'sd0,       1'b0, 0);
        add_request(OP_TRAVERSE,     0,   32'sd0,       1'b0, 0);
        add_request(OP_DELETE_FRONT, 0,   32'sd0,       1'b0, 0);
        add_request(OP_DELETE_END,   0,   32'sd0,       1'b0, 0);
        add_request(OP_TRAVERSE,     0,   32'sd0,       1'b0, 0);

        // Random part, in segments: two growing segments fill the list until
        // the full rejections show up, a mixed one churns it, two shrinking ones
        // drain it to empty and a further mixed one churns it. The first shrinking
        // segment starts only once every owed result has come. The pattern of six
        // segments repeats, and the idling phase steps every PHASE_SPAN requests.
        seg_index    = 0;
        random_count = 0;
        while (random_count < RANDOM_REQUESTS) begin
            seg_kind = seg_index % 6;
            seg_len  = $urandom_range(20, 45);
            case (seg_kind)
                0, 1:    begin insert_limit = 70; delete_limit = 85; end
                3, 4:    begin insert_limit = 20; delete_limit = 88; end
                default: begin insert_limit = 45; delete_limit = 85; end
            endcase
            for (int n = 0; n < seg_len; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < insert_limit) begin
                    op = t_op'($urandom_range(OP_INSERT_AT, OP_APPEND));
                end else if (roll < delete_limit) begin
                    op = t_op'($urandom_range(OP_DELETE_AT, OP_DELETE_END));
                end else if (roll < 97) begin
                    op = OP_TRAVERSE;
                end else begin
                    op = OP_NOP;
                end
                // Mostly positions around the list length; sometimes the
                // whole field, so the high bits toggle too.
                pos = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 36)
                                                   : $urandom_range(0, 255);
                case ($urandom_range(0, 24))
                    0:       value = VALUE_MIN;
                    1:       value = VALUE_MAX;
                    2:       value = -32'sd1;
                    3:       value = 32'sd0;
                    default: value = $urandom;
                endcase
                add_request(op, pos, value, (seg_kind == 3 && n == 0),
                            (random_count / PHASE_SPAN) % 4);
                random_count++;
            end
            seg_index++;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every request has been taken, every owed result has come,
        // and a quiet stretch shows that nothing extra follows.
        while (pending_requests.size() != 0 || i_in_valid) begin
            @(posedge i_clk);
        end
        while (owed_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d requests and %0d checked results in %0d cycles.",
                 requests_accepted, results_checked, cycle_count);
        $display("Longest list held %0d values; %0d requests were refused on a full list.",
                 longest_list, full_rejections);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
